// ===== hdl/md5_stream_hasher_top_macros.svh =====
// Assertion macros for the MD5 hasher.
`ifndef MD5_STREAM_HASHER_TOP_MACROS_SVH
`define MD5_STREAM_HASHER_TOP_MACROS_SVH

// An implication checked at every clock edge outside reset.
`define MD5_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// A condition that holds at every clock edge outside reset.
`define MD5_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

// ===== hdl/md5_pkg.sv =====
package md5_pkg;

   typedef logic [31:0] word_type;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_COMPRESS,
      ST_FOLD,
      ST_PAD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       write_byte;
      logic [5:0] write_addr;
      logic [7:0] write_data;
      logic       round_start;
      logic       round_step;
      logic [5:0] round_index;
      logic       fold;
      logic       init_chain;
      logic [1:0] emit_index;
   } md5_cmd_type;

   function automatic word_type round_const(input logic [5:0] r);
      word_type k;
      unique case (r)
         6'd0: k = 32'hd76aa478;   6'd1: k = 32'he8c7b756;
         6'd2: k = 32'h242070db;   6'd3: k = 32'hc1bdceee;
         6'd4: k = 32'hf57c0faf;   6'd5: k = 32'h4787c62a;
         6'd6: k = 32'ha8304613;   6'd7: k = 32'hfd469501;
         6'd8: k = 32'h698098d8;   6'd9: k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
         default: k = '0;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [5:0] r);
      logic [4:0] s;
      unique case ({r[5:4], r[1:0]})
         4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
         4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
         4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
         4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
         default: s = 5'd0;
      endcase
      return s;
   endfunction

   function automatic logic [3:0] msg_index(input logic [5:0] r);
      logic [3:0] g;
      unique case (r[5:4])
         2'd0: g = r[3:0];
         2'd1: g = 4'(5 * r[3:0] + 1);
         2'd2: g = 4'(3 * r[3:0] + 5);
         2'd3: g = 4'(7 * r[3:0]);
         default: g = '0;
      endcase
      return g;
   endfunction

endpackage

// ===== hdl/md5_if.sv =====
interface md5_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] data_byte;
   modport source (output valid, output cmd, output data_byte, input ready);
   modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface md5_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  word_index;
   logic [31:0] digest_word;
   logic        last;
   modport source (output valid, output word_index, output digest_word, output last,
                   input ready);
   modport sink (input valid, input word_index, input digest_word, input last,
                 output ready);
endinterface

// ===== hdl/md5_stream_hasher_top.sv =====
// Channel  Role   Word
// req_     sink   cmd, data_byte
// rsp_     source word_index, digest_word, last
// The 64th absorbed byte of a block starts a compression, run by the single
// round unit (one MD5 round per cycle) and its fold; no input is taken meanwhile.
// A finish pads one byte a cycle, runs one or two compressions, then
// presents the four digest words, each held until taken.
// Reset is synchronous and restores the initial chaining value.
`include "md5_stream_hasher_top_macros.svh"

module md5_stream_hasher_top (
   input logic clock,
   input logic reset,
   md5_req_if.sink   req,
   md5_rsp_if.source rsp
);
   import md5_pkg::*;

   md5_cmd_type  cmd;
   logic [31:0]  chain_word;

   md5_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req.valid),
      .req_ready      (req.ready),
      .req_cmd        (req.cmd),
      .req_data_byte  (req.data_byte),
      .rsp_valid      (rsp.valid),
      .rsp_ready      (rsp.ready),
      .rsp_word_index (rsp.word_index),
      .rsp_last       (rsp.last),
      .cmd            (cmd)
   );

   md5_datapath u_datapath (
      .clock      (clock),
      .cmd        (cmd),
      .chain_word (chain_word)
   );

   assign rsp.digest_word = chain_word;

   `MD5_ASSERT_IMPL(a_no_overlap, clock, reset, rsp.valid, !req.ready, "input taken during digest")
   `MD5_ASSERT_IMPL(a_last_idx, clock, reset, rsp.valid && rsp.last, rsp.word_index == 2'd3, "last misplaced")
   `MD5_ASSERT_ALWAYS(a_cmd_excl, clock, reset, !(cmd.fold && cmd.round_step), "fold during round")
endmodule

// ===== hdl/md5_datapath.sv =====
module md5_datapath (
   input  logic                clock,
   input  md5_pkg::md5_cmd_type cmd,
   output logic [31:0]         chain_word
);
   import md5_pkg::*;

   logic [31:0] block_mem [16];
   logic [31:0] w_ff;
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] a_in, b_in, c_in, d_in;
   logic [31:0] h_ff [4];
   logic [31:0] f_val, sum_val, rot_val;
   logic [5:0]  r;
   logic [5:0]  rd_index;

   assign r = cmd.round_index;

   // While a round runs, fetch the message word of the following round.
   assign rd_index = cmd.round_step ? 6'(cmd.round_index + 6'd1) : cmd.round_index;

   always_ff @(posedge clock) begin
      if (cmd.write_byte) begin
         block_mem[cmd.write_addr[5:2]][8*cmd.write_addr[1:0] +: 8] <= cmd.write_data;
      end
      w_ff <= block_mem[msg_index(rd_index)];
   end

   always_comb begin
      unique case (r[5:4])
         2'd0: f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f_val = (b_ff & d_ff) | (c_ff & ~d_ff);
         2'd2: f_val = b_ff ^ c_ff ^ d_ff;
         default: f_val = c_ff ^ (b_ff | ~d_ff);
      endcase
      sum_val = a_ff + f_val + round_const(r) + w_ff;
      rot_val = (sum_val << rot_amount(r)) | (sum_val >> (6'd32 - {1'b0, rot_amount(r)}));
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      if (cmd.round_start) begin
         a_in = h_ff[0];
         b_in = h_ff[1];
         c_in = h_ff[2];
         d_in = h_ff[3];
      end else if (cmd.round_step) begin
         a_in = d_ff;
         b_in = b_ff + rot_val;
         c_in = b_ff;
         d_in = c_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      if (cmd.init_chain) begin
         h_ff[0] <= 32'h67452301;
         h_ff[1] <= 32'hefcdab89;
         h_ff[2] <= 32'h98badcfe;
         h_ff[3] <= 32'h10325476;
      end else if (cmd.fold) begin
         h_ff[0] <= h_ff[0] + a_ff;
         h_ff[1] <= h_ff[1] + b_ff;
         h_ff[2] <= h_ff[2] + c_ff;
         h_ff[3] <= h_ff[3] + d_ff;
      end
   end

   assign chain_word = h_ff[cmd.emit_index];
endmodule

// ===== hdl/md5_ctrl.sv =====
module md5_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_cmd,
   input  logic [7:0]           req_data_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_word_index,
   output logic                 rsp_last,
   output md5_pkg::md5_cmd_type  cmd
);
   import md5_pkg::*;

   state_type   state_ff, state_in;
   logic [63:0] len_ff, len_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [5:0]  pos_ff, pos_in;
   logic        fin_ff, fin_in;
   logic        lenblk_ff, lenblk_in;
   logic [1:0]  emit_ff, emit_in;
   logic [7:0]  len_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         len_ff <= '0;
         cnt_ff <= '0;
         pos_ff <= '0;
         fin_ff <= 1'b0;
         lenblk_ff <= 1'b0;
         emit_ff <= '0;
      end else begin
         state_ff <= state_in;
         len_ff <= len_in;
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
         fin_ff <= fin_in;
         lenblk_ff <= lenblk_in;
         emit_ff <= emit_in;
      end
   end

   assign len_byte = len_ff[8*pos_ff[2:0] +: 8];

   always_comb begin
      state_in = state_ff;
      len_in = len_ff;
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      fin_in = fin_ff;
      lenblk_in = lenblk_ff;
      emit_in = emit_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd = '0;
      cmd.round_index = cnt_ff[5:0];
      cmd.emit_index = emit_ff;
      unique case (state_ff)
         ST_FILL: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.write_byte = 1'b1;
               cmd.write_addr = len_ff[8:3];
               if (!req_cmd) begin
                  cmd.write_data = req_data_byte;
                  len_in = len_ff + 64'd8;
                  if (len_ff[8:3] == 6'd63) begin
                     fin_in = 1'b0;
                     cnt_in = '0;
                     state_in = ST_COMPRESS;
                  end
               end else begin
                  cmd.write_data = 8'h80;
                  pos_in = 6'(len_ff[8:3] + 6'd1);
                  lenblk_in = (len_ff[8:3] < 6'd56);
                  fin_in = 1'b1;
                  if (len_ff[8:3] == 6'd63) begin
                     cnt_in = '0;
                     state_in = ST_COMPRESS;
                  end else begin
                     state_in = ST_PAD;
                  end
               end
               cmd.round_start = 1'b1;
               cmd.round_index = '0;
            end
         end
         ST_PAD: begin
            cmd.write_byte = 1'b1;
            cmd.write_addr = pos_ff;
            cmd.write_data = (lenblk_ff && pos_ff >= 6'd56) ? len_byte : 8'h00;
            pos_in = 6'(pos_ff + 6'd1);
            cmd.round_start = 1'b1;
            cmd.round_index = '0;
            if (pos_ff == 6'd63) begin
               cnt_in = '0;
               state_in = ST_COMPRESS;
            end
         end
         ST_COMPRESS: begin
            // Count 0 loads the message word for round 0; rounds run on 1..64.
            cmd.round_index = 6'(cnt_ff);
            if (cnt_ff != 7'd0) begin
               cmd.round_step = 1'b1;
               cmd.round_index = 6'(cnt_ff - 7'd1);
               if (cnt_ff != 7'd64) begin
                  cmd.round_index = 6'(cnt_ff - 7'd1);
               end
            end
            cnt_in = 7'(cnt_ff + 7'd1);
            if (cnt_ff == 7'd64) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            if (!fin_ff) begin
               state_in = ST_FILL;
            end else if (!lenblk_ff) begin
               lenblk_in = 1'b1;
               pos_in = '0;
               state_in = ST_PAD;
            end else begin
               emit_in = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               emit_in = 2'(emit_ff + 2'd1);
               if (emit_ff == 2'd3) begin
                  cmd.init_chain = 1'b1;
                  len_in = '0;
                  fin_in = 1'b0;
                  state_in = ST_FILL;
               end
            end
         end
         default: state_in = ST_FILL;
      endcase
      if (reset) begin
         cmd.init_chain = 1'b1;
      end
   end

   assign rsp_word_index = emit_ff;
   assign rsp_last = (emit_ff == 2'd3);
endmodule

// ===== bench/md5_stream_hasher_top_tb.sv =====
`timescale 1ns / 1ps

module md5_stream_hasher_top_tb;
   import md5_pkg::*;

   typedef struct {
      logic [1:0]  index;
      logic [31:0] word;
      logic        last;
   } digest_word_type;

   localparam logic CMD_ABSORB = 1'b0;
   localparam logic CMD_FINISH = 1'b1;
   localparam int unsigned CYCLE_LIMIT = 50000;

   logic clock;
   logic reset;

   md5_req_if req ();
   md5_rsp_if rsp ();

   md5_stream_hasher_top u_dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   logic [31:0] chain [4];
   logic [7:0] block_buf [64];
   logic [63:0] length_bits;
   digest_word_type digest_queue [$];
   int unsigned mismatch_count;
   int unsigned digest_count;
   int unsigned word_count;
   int unsigned message_count;
   int unsigned cycle_count;
   int unsigned rsp_wait;
   int unsigned seen_count;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [31:0] md5_sine(input int r);
      return 32'(longint'($floor($pow(2.0, 32.0) * $sin(real'(r + 1)) < 0.0 ?
         -$pow(2.0, 32.0) * $sin(real'(r + 1)) : $pow(2.0, 32.0) * $sin(real'(r + 1)))));
   endfunction

   function automatic void chain_init();
      chain[0] = 32'h67452301;
      chain[1] = 32'hefcdab89;
      chain[2] = 32'h98badcfe;
      chain[3] = 32'h10325476;
      length_bits = '0;
   endfunction

   function automatic void compress_buf();
      logic [31:0] m [16];
      logic [31:0] a, b, c, d, f, sum, tmp;
      int g, s;
      int shifts [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
      for (int i = 0; i < 16; i++)
         m[i] = {block_buf[4*i+3], block_buf[4*i+2], block_buf[4*i+1], block_buf[4*i]};
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int r = 0; r < 64; r++) begin
         case (r / 16)
            0: begin f = (b & c) | (~b & d); g = r; end
            1: begin f = (b & d) | (c & ~d); g = (5 * r + 1) % 16; end
            2: begin f = b ^ c ^ d; g = (3 * r + 5) % 16; end
            default: begin f = c ^ (b | ~d); g = (7 * r) % 16; end
         endcase
         s = shifts[(r / 16) * 4 + r % 4];
         sum = a + f + md5_sine(r) + m[g];
         tmp = d;
         d = c;
         c = b;
         b = b + ((sum << s) | (sum >> (32 - s)));
         a = tmp;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
   endfunction

   function automatic void predict_word(input logic cmd, input logic [7:0] data);
      int pos;
      digest_word_type dw;
      pos = int'(length_bits[8:3]);
      if (cmd == CMD_ABSORB) begin
         block_buf[pos] = data;
         length_bits += 64'd8;
         if (pos == 63) compress_buf();
         return;
      end
      block_buf[pos] = 8'h80;
      for (int k = pos + 1; k < 64; k++) block_buf[k] = 8'h00;
      if (pos >= 56) begin
         compress_buf();
         for (int k = 0; k < 64; k++) block_buf[k] = 8'h00;
      end
      for (int k = 0; k < 8; k++) block_buf[56+k] = length_bits[8*k +: 8];
      compress_buf();
      for (int k = 0; k < 4; k++) begin
         dw.index = 2'(k);
         dw.word = chain[k];
         dw.last = (k == 3);
         digest_queue.push_back(dw);
      end
      chain_init();
   endfunction

   task automatic send_word(input logic cmd, input logic [7:0] data);
      int gap;
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
         req.valid <= 1'b0;
         req.cmd <= 1'($urandom_range(0, 1));
         req.data_byte <= 8'($urandom_range(0, 255));
         repeat (gap) @(negedge clock);
      end
      req.valid <= 1'b1;
      req.cmd <= cmd;
      req.data_byte <= data;
      do @(posedge clock); while (!req.ready);
      predict_word(cmd, data);
      word_count++;
      if (cmd == CMD_FINISH) message_count++;
      @(negedge clock);
   endtask

   task automatic send_message(input int n, input bit fill_ones);
      for (int i = 0; i < n; i++)
         send_word(CMD_ABSORB, fill_ones ? 8'hff : 8'($urandom_range(0, 255)));
      send_word(CMD_FINISH, 8'($urandom_range(0, 255)));
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      do @(negedge clock); while (digest_queue.size() != 0);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         rsp_wait = $urandom_range(0, 6);
         seen_count = 0;
      end else begin
         if (digest_count != seen_count) begin
            seen_count = digest_count;
            rsp_wait = $urandom_range(0, 6);
         end
         if (rsp_wait != 0) begin
            rsp.ready <= 1'b0;
            if (rsp.valid) rsp_wait--;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      digest_word_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         digest_count++;
         if (digest_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected digest word %h", rsp.digest_word);
         end else begin
            want = digest_queue.pop_front();
            if (rsp.word_index !== want.index || rsp.digest_word !== want.word ||
                rsp.last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %0d %h %b, got %0d %h %b", want.index,
                     want.word, want.last, rsp.word_index, rsp.digest_word, rsp.last);
            end
         end
      end
   end

   task automatic test_directed();
      send_word(CMD_FINISH, 8'h00);
      send_message(1, 1'b0);
      send_word(CMD_ABSORB, 8'h00);
      send_word(CMD_ABSORB, 8'hff);
      send_word(CMD_FINISH, 8'hff);
      send_message(3, 1'b1);
      drain();
   endtask

   task automatic test_block_edges();
      send_message(127, 1'b0);
      drain();
   endtask

   task automatic test_random_messages();
      for (int i = 0; i < 6; i++) begin
         send_message($urandom_range(0, 3), 1'b0);
         if (i == 2) drain();
      end
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req.valid = 1'b0;
      req.cmd = CMD_ABSORB;
      req.data_byte = 8'h00;
      mismatch_count = 0;
      digest_count = 0;
      word_count = 0;
      message_count = 0;
      cycle_count = 0;
      chain_init();
      for (int k = 0; k < 64; k++) block_buf[k] = 8'h00;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_block_edges();
      test_random_messages();
      repeat (200) @(negedge clock);
      $display("Hashed %0d messages from %0d input words, including empty and long-tail.",
         message_count, word_count);
      $display("Checked %0d digest words under random stalls.", digest_count);
      if (mismatch_count == 0 && digest_queue.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/md5_pkg.sv
hdl/md5_if.sv
hdl/md5_datapath.sv
hdl/md5_ctrl.sv
hdl/md5_stream_hasher_top.sv
bench/md5_stream_hasher_top_tb.sv
